[sv/cse_pkg.sv]
// Package for the CAN signal extractor: request and stage types, command and
// status codes, fixed-point limits. No dependencies.
`default_nettype none

package cse_pkg;

  // Result kind selected per request
  typedef enum logic [1:0] {
    CMD_FIXED = 2'd0,
    CMD_SINT  = 2'd1,
    CMD_UINT  = 2'd2,
    CMD_BOOL  = 2'd3
  } cmd_e;

  // Status codes returned with each result
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_LEN = 2'd1,
    ST_OUTSIDE = 2'd2
  } status_e;

  localparam int unsigned FRAC_BITS = 24;
  localparam int unsigned MAX_DLC   = 8;
  localparam int unsigned MAX_LEN   = 64;

  // Product magnitude cap: beyond it the sum always saturates
  localparam logic [63:0] PROD_CAP    = 64'h8001_0000_0000_0000;
  localparam logic [63:0] POS_LIMIT   = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] NEG_LIMIT   = 64'h8000_0000_0000_0000;

  // One input request as registered at the port
  typedef struct packed {
    logic [63:0]        data;
    logic [3:0]         dlc;
    logic [5:0]         sb;
    logic [6:0]         len;
    logic               sgn;
    logic               order;
    logic signed [31:0] scale;
    logic signed [47:0] offset;
    cmd_e               cmd;
  } item_t;

  // Fields that travel unchanged down to the result
  typedef struct packed {
    logic [63:0] raw;
    status_e     status;
    cmd_e        cmd;
  } tag_t;

  // Extracted field and operand magnitudes
  typedef struct packed {
    tag_t        tag;
    logic        xneg;
    logic [63:0] xmag;
    logic        sneg;
    logic [31:0] smag;
    logic        oneg;
    logic [47:0] omag;
  } ext_t;

  // Saturated physical value with its magnitude
  typedef struct packed {
    tag_t        tag;
    logic [63:0] v;
    logic [63:0] vmag;
  } val_t;

endpackage

`default_nettype wire

[sv/cse_extract.sv]
// Field extraction for the CAN signal extractor: range checks, byte-order
// handling, bit-field select, sign handling. Depends on cse_pkg.
`default_nettype none

module cse_extract (
  input  cse_pkg::item_t item_i,
  output cse_pkg::ext_t  ext_o
);
  import cse_pkg::*;

  logic [6:0]  dlc8;
  logic        bad;
  logic [63:0] mask;
  logic        intel_out;
  logic        moto_out;
  logic [2:0]  msb_byte;
  logic [5:0]  msb;
  logic [7:0]  moto_sh;
  logic [63:0] rev;
  logic [63:0] src;
  logic [5:0]  sh;
  logic [63:0] field;
  status_e     status;
  logic [63:0] raw;
  logic        xneg;

  // Range checks for both byte orders
  always_comb begin
    dlc8      = {item_i.dlc, 3'b000};
    bad       = (item_i.dlc > 4'(MAX_DLC)) || (item_i.len == 7'd0) ||
                (item_i.len > 7'(MAX_LEN));
    mask      = {64{1'b1}} >> (7'(MAX_LEN) - item_i.len);
    intel_out = ({1'b0, item_i.sb} >= dlc8) ||
                ({2'b00, item_i.sb} + {1'b0, item_i.len} > {1'b0, dlc8});
    // Motorola: MSB in sawtooth numbering mapped into the byte-reversed frame
    msb_byte  = item_i.dlc[2:0] - 3'd1 - item_i.sb[5:3];
    msb       = {msb_byte, item_i.sb[2:0]};
    moto_out  = ({1'b0, item_i.sb} >= dlc8) ||
                ({1'b0, msb} + 7'd1 < item_i.len);
    // Shift in the fully reversed word; independent of dlc when in frame
    moto_sh   = 8'd57 - {2'b00, item_i.sb[5:3], 3'b000} +
                {5'b00000, item_i.sb[2:0]} - {1'b0, item_i.len};
  end

  // Byte reversal and single field shifter
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      rev[8*(7-i) +: 8] = item_i.data[8*i +: 8];
    end
    src   = item_i.order ? item_i.data : rev;
    sh    = item_i.order ? item_i.sb : moto_sh[5:0];
    field = (src >> sh) & mask;
  end

  // Status, raw field and operand magnitudes
  always_comb begin
    priority if (bad) begin
      status = ST_BAD_LEN;
    end else if (item_i.order ? intel_out : moto_out) begin
      status = ST_OUTSIDE;
    end else begin
      status = ST_OK;
    end
    raw  = (status == ST_OK) ? field : 64'd0;
    xneg = item_i.sgn && (|(raw & (mask ^ (mask >> 1))));

    ext_o.tag.raw    = raw;
    ext_o.tag.status = status;
    ext_o.tag.cmd    = item_i.cmd;
    ext_o.xneg       = xneg;
    ext_o.xmag       = xneg ? (64'd0 - (raw | ~mask)) : raw;
    ext_o.sneg       = item_i.scale[31];
    ext_o.smag       = item_i.scale[31] ? (32'd0 - $unsigned(item_i.scale))
                                        : $unsigned(item_i.scale);
    ext_o.oneg       = item_i.offset[47];
    ext_o.omag       = item_i.offset[47] ? (48'd0 - $unsigned(item_i.offset))
                                         : $unsigned(item_i.offset);
  end

endmodule

`default_nettype wire

[sv/cse_arith.sv]
// Scaling pipeline for the CAN signal extractor: split 64x32 product, cap,
// sign-magnitude offset add, saturation to int64. Depends on cse_pkg.
`default_nettype none

module cse_arith (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           vld_i,
  input  cse_pkg::ext_t  ext_i,
  output logic           vld_o,
  output cse_pkg::val_t  val_o
);
  import cse_pkg::*;

  typedef struct packed {
    tag_t        tag;
    logic [63:0] p0;
    logic [63:0] p1;
    logic        xsneg;
    logic        oneg;
    logic [47:0] omag;
  } prod_t;

  typedef struct packed {
    tag_t        tag;
    logic [63:0] pmag;
    logic        pneg;
    logic        oneg;
    logic [47:0] omag;
  } pm_t;

  typedef struct packed {
    tag_t        tag;
    logic        neg;
    logic [63:0] mag;
  } sm_t;

  logic [3:0]  vld_q;
  prod_t       prod_d, prod_q;
  pm_t         pm_d, pm_q;
  sm_t         sm_d, sm_q;
  val_t        val_d, val_q;
  logic [64:0] sum65;
  logic        cap;
  logic [63:0] omag64;
  logic [64:0] diff65;

  // Two 32x32 partial products of the field magnitude and the scale
  always_comb begin
    prod_d.tag   = ext_i.tag;
    prod_d.p0    = 64'(ext_i.xmag[31:0]) * 64'(ext_i.smag);
    prod_d.p1    = 64'(ext_i.xmag[63:32]) * 64'(ext_i.smag);
    prod_d.xsneg = ext_i.xneg ^ ext_i.sneg;
    prod_d.oneg  = ext_i.oneg;
    prod_d.omag  = ext_i.omag;
  end

  // Combine partial products, cap the magnitude
  always_comb begin
    sum65     = {1'b0, prod_q.p0} + {1'b0, prod_q.p1[31:0], 32'd0};
    cap       = (|prod_q.p1[63:32]) || sum65[64] || (sum65[63:0] > PROD_CAP);
    pm_d.tag  = prod_q.tag;
    pm_d.pmag = cap ? PROD_CAP : sum65[63:0];
    pm_d.pneg = prod_q.xsneg && (cap || (sum65[63:0] != 64'd0));
    pm_d.oneg = prod_q.oneg;
    pm_d.omag = prod_q.omag;
  end

  // Sign-magnitude add of product and offset
  always_comb begin
    omag64   = {16'd0, pm_q.omag};
    diff65   = {1'b0, pm_q.pmag} - {1'b0, omag64};
    sm_d.tag = pm_q.tag;
    priority if (pm_q.pneg == pm_q.oneg) begin
      sm_d.neg = pm_q.pneg;
      sm_d.mag = pm_q.pmag + omag64;
    end else if (!diff65[64]) begin
      sm_d.neg = pm_q.pneg;
      sm_d.mag = diff65[63:0];
    end else begin
      sm_d.neg = pm_q.oneg;
      sm_d.mag = omag64 - pm_q.pmag;
    end
  end

  // Saturate to the signed 64-bit range
  always_comb begin
    val_d.tag = sm_q.tag;
    if (sm_q.neg) begin
      val_d.vmag = (sm_q.mag > NEG_LIMIT) ? NEG_LIMIT : sm_q.mag;
      val_d.v    = 64'd0 - val_d.vmag;
    end else begin
      val_d.vmag = (sm_q.mag > POS_LIMIT) ? POS_LIMIT : sm_q.mag;
      val_d.v    = val_d.vmag;
    end
  end

  // Stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[2:0], vld_i};
    end
  end

  // Stage payload registers
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
      pm_q   <= pm_d;
      sm_q   <= sm_d;
      val_q  <= val_d;
    end
  end

  assign vld_o = vld_q[3];
  assign val_o = val_q;

endmodule

`default_nettype wire

[sv/cse_format.sv]
// Result formatting for the CAN signal extractor: fixed, truncated integer,
// clamped unsigned or nonzero flag, and the bad-length override. Depends on cse_pkg.
`default_nettype none

module cse_format (
  input  cse_pkg::val_t val_i,
  output logic [63:0]   value_o,
  output logic [63:0]   raw_o,
  output logic [1:0]    status_o
);
  import cse_pkg::*;

  logic        vneg;
  logic [63:0] ipart;

  // Command selection on the saturated value
  always_comb begin
    vneg  = val_i.v[63];
    ipart = val_i.vmag >> FRAC_BITS;
    unique case (val_i.tag.cmd)
      CMD_FIXED: value_o = val_i.v;
      CMD_SINT:  value_o = vneg ? (64'd0 - ipart) : ipart;
      CMD_UINT:  value_o = vneg ? 64'd0 : (val_i.v >> FRAC_BITS);
      CMD_BOOL:  value_o = {63'd0, |val_i.v};
      default:   value_o = val_i.v;
    endcase
    if (val_i.tag.status == ST_BAD_LEN) begin
      value_o = 64'd0;
    end
    raw_o    = val_i.tag.raw;
    status_o = val_i.tag.status;
  end

endmodule

`default_nettype wire

[sv/can_signal_extractor.sv]
// CAN signal extractor top level: input register, field extraction, scaling pipeline, output register.
// Each request passes the input, extract, scaling and output registers before valid_o shows it.
// Throughput: one request per cycle; the whole pipeline advances together, held only
// while a result sits in the output register with stall_i high (stall_o then high).
// Reset: rst_ni asynchronous, active low, clears all stage valid bits; no other state.
// Depends on cse_pkg, cse_extract, cse_arith, cse_format.
`default_nettype none

module can_signal_extractor (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               stall_o,
  input  logic [63:0]        frame_data_i,
  input  logic [3:0]         frame_length_i,
  input  logic [5:0]         start_bit_i,
  input  logic [6:0]         bit_length_i,
  input  logic               is_signed_i,
  input  logic               byte_order_i,
  input  logic signed [31:0] scale_i,
  input  logic signed [47:0] offset_i,
  input  logic [1:0]         command_i,
  output logic               valid_o,
  input  logic               stall_i,
  output logic signed [63:0] value_o,
  output logic [63:0]        raw_field_o,
  output logic [1:0]         status_o
);
  import cse_pkg::*;

  logic        en;
  logic        in_vld_q;
  item_t       in_d, in_q;
  ext_t        ext_d, ext_q;
  logic        ext_vld_q;
  logic        val_vld;
  val_t        val;
  logic [63:0] value_d, value_q;
  logic [63:0] raw_d, raw_q;
  logic [1:0]  status_d, status_q;
  logic        out_vld_q;

  // Pipeline advances unless a held result is stalled
  assign en      = !out_vld_q || !stall_i;
  assign stall_o = !en;

  always_comb begin
    in_d.data   = frame_data_i;
    in_d.dlc    = frame_length_i;
    in_d.sb     = start_bit_i;
    in_d.len    = bit_length_i;
    in_d.sgn    = is_signed_i;
    in_d.order  = byte_order_i;
    in_d.scale  = scale_i;
    in_d.offset = offset_i;
    in_d.cmd    = cmd_e'(command_i);
  end

  cse_extract u_extract (
    .item_i (in_q),
    .ext_o  (ext_d)
  );

  cse_arith u_arith (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (ext_vld_q),
    .ext_i  (ext_q),
    .vld_o  (val_vld),
    .val_o  (val)
  );

  cse_format u_format (
    .val_i    (val),
    .value_o  (value_d),
    .raw_o    (raw_d),
    .status_o (status_d)
  );

  // Valid bits of input, extract and output stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      ext_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      in_vld_q  <= valid_i;
      ext_vld_q <= in_vld_q;
      out_vld_q <= val_vld;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (en) begin
      in_q     <= in_d;
      ext_q    <= ext_d;
      value_q  <= value_d;
      raw_q    <= raw_d;
      status_q <= status_d;
    end
  end

  assign valid_o     = out_vld_q;
  assign value_o     = $signed(value_q);
  assign raw_field_o = raw_q;
  assign status_o    = status_q;

endmodule

`default_nettype wire

[sv/cse_checker.sv]
// Port-level checker for the CAN signal extractor, bound to the top level.
// Depends on cse_pkg for status codes.
`default_nettype none

module cse_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               valid_i,
  input logic               stall_o,
  input logic               valid_o,
  input logic               stall_i,
  input logic signed [63:0] value_o,
  input logic [63:0]        raw_field_o,
  input logic [1:0]         status_o
);
  import cse_pkg::*;

  // Back-pressure only while a result is held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> (valid_o && stall_i))
    else $error("stall_o raised without a held result");

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && stall_i) |=> (valid_o && $stable(value_o) && $stable(raw_field_o) &&
                              $stable(status_o)))
    else $error("stalled result changed");

  // Bad length gives zero value and raw field
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && (status_o == ST_BAD_LEN)) |-> (value_o == 64'sd0 && raw_field_o == 64'd0))
    else $error("bad-length result not zero");

  // Field outside the frame gives zero raw field
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && (status_o == ST_OUTSIDE)) |-> (raw_field_o == 64'd0))
    else $error("outside-frame raw field not zero");

  // Only defined status codes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (status_o == ST_OK || status_o == ST_BAD_LEN || status_o == ST_OUTSIDE))
    else $error("undefined status code");

endmodule

bind can_signal_extractor cse_checker u_cse_checker (.*);

`default_nettype wire

[tb/sv/tb_top.sv]
// Testbench for can_signal_extractor: directed and random signal requests with a
// scoreboard that predicts each decoded value, checked field by field on return.
// Depends on cse_pkg and the can_signal_extractor RTL.

module tb_top;
  import cse_pkg::*;

  localparam logic ORDER_MOTOROLA = 1'b0;
  localparam logic ORDER_INTEL    = 1'b1;
  localparam logic [31:0] SCALE_ONE = 32'h0100_0000;

  // Expected outcome of one request
  typedef struct packed {
    logic [63:0] value;
    logic [63:0] raw;
    status_e     status;
  } signal_result_t;

  // Predicts decoded signals and matches them against returned results
  class signal_scoreboard;
    signal_result_t pending_results[$];
    int unsigned mismatches;
    int unsigned checked;
    int unsigned n_ok;
    int unsigned n_bad_len;
    int unsigned n_outside;

    function new();
      mismatches = 0;
      checked    = 0;
      n_ok       = 0;
      n_bad_len  = 0;
      n_outside  = 0;
    endfunction

    // Bit-exact decode of one request
    function signal_result_t decode_signal(item_t r);
      signal_result_t o;
      logic [63:0]  raw, w, lmask, xmag, smag, omag, pmag, v, vmag, s64, o64;
      logic [127:0] prod;
      logic [64:0]  mag;
      logic         xneg, sneg, oneg, pneg, neg, vneg;
      int unsigned  dlc_n, sb_n, len, fbits, msb, i;

      dlc_n = r.dlc;
      sb_n  = r.sb;
      len   = r.len;
      fbits = dlc_n * 8;
      if (dlc_n > MAX_DLC || len == 0 || len > MAX_LEN) begin
        o.value  = 64'd0;
        o.raw    = 64'd0;
        o.status = ST_BAD_LEN;
        return o;
      end
      raw      = 64'd0;
      o.status = ST_OK;
      lmask    = (len >= MAX_LEN) ? {64{1'b1}} : ((64'd1 << len) - 64'd1);

      // Field extraction
      if (r.order == ORDER_INTEL) begin
        if (sb_n + len > fbits) o.status = ST_OUTSIDE;
        else raw = (r.data >> sb_n) & lmask;
      end else if (sb_n >= fbits) begin
        o.status = ST_OUTSIDE;
      end else begin
        // sawtooth start bit -> MSB position in the big-endian word
        msb = (dlc_n - 1 - sb_n / 8) * 8 + sb_n % 8;
        if (msb < len - 1) begin
          o.status = ST_OUTSIDE;
        end else begin
          w = 64'd0;
          for (i = 0; i < dlc_n; i++) w[(dlc_n - 1 - i) * 8 +: 8] = r.data[i * 8 +: 8];
          raw = (w >> (msb - (len - 1))) & lmask;
        end
      end
      o.raw = raw;

      // Sign and magnitude of operands
      xneg = r.sgn && raw[len - 1];
      xmag = xneg ? (64'd0 - (raw | ~lmask)) : raw;
      s64  = {{32{r.scale[31]}}, r.scale};
      sneg = r.scale[31];
      smag = sneg ? (64'd0 - s64) : s64;
      o64  = {{16{r.offset[47]}}, r.offset};
      oneg = r.offset[47];
      omag = oneg ? (64'd0 - o64) : o64;

      // Product, capped where the sum must saturate anyway
      prod = {64'd0, xmag} * {64'd0, smag};
      pmag = (prod > {64'd0, PROD_CAP}) ? PROD_CAP : prod[63:0];
      pneg = (xneg != sneg) && (pmag != 64'd0);

      // Sign-magnitude sum, then saturate to 64-bit signed
      if (pneg == oneg) begin
        neg = pneg;
        mag = {1'b0, pmag} + {1'b0, omag};
      end else if (pmag >= omag) begin
        neg = pneg;
        mag = {1'b0, pmag - omag};
      end else begin
        neg = oneg;
        mag = {1'b0, omag - pmag};
      end
      if (!neg) v = (mag > {1'b0, POS_LIMIT}) ? POS_LIMIT : mag[63:0];
      else v = (mag > {1'b0, NEG_LIMIT}) ? NEG_LIMIT : (64'd0 - mag[63:0]);

      // Output form per command
      vneg = v[63];
      vmag = vneg ? (64'd0 - v) : v;
      case (r.cmd)
        CMD_FIXED: o.value = v;
        CMD_SINT:  o.value = vneg ? (64'd0 - (vmag >> FRAC_BITS)) : (vmag >> FRAC_BITS);
        CMD_UINT:  o.value = vneg ? 64'd0 : (v >> FRAC_BITS);
        default:   o.value = (v != 64'd0) ? 64'd1 : 64'd0;
      endcase
      return o;
    endfunction

    function void note_request(item_t r);
      pending_results.push_back(decode_signal(r));
    endfunction

    function void check_result(logic [63:0] value, logic [63:0] raw, logic [1:0] status);
      signal_result_t want;
      if (pending_results.size() == 0) begin
        $error("unexpected result: value %h raw_field %h status %0d", value, raw, status);
        mismatches++;
        return;
      end
      want = pending_results.pop_front();
      checked++;
      case (want.status)
        ST_OK:      n_ok++;
        ST_BAD_LEN: n_bad_len++;
        default:    n_outside++;
      endcase
      if (value !== want.value) begin
        $error("value: expected %h, got %h", want.value, value);
        mismatches++;
      end
      if (raw !== want.raw) begin
        $error("raw_field: expected %h, got %h", want.raw, raw);
        mismatches++;
      end
      if (status !== 2'(want.status)) begin
        $error("status: expected %0d, got %0d", want.status, status);
        mismatches++;
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               valid_i;
  logic               stall_o;
  logic [63:0]        frame_data_i;
  logic [3:0]         frame_length_i;
  logic [5:0]         start_bit_i;
  logic [6:0]         bit_length_i;
  logic               is_signed_i;
  logic               byte_order_i;
  logic signed [31:0] scale_i;
  logic signed [47:0] offset_i;
  logic [1:0]         command_i;
  logic               valid_o;
  logic               stall_i;
  logic signed [63:0] value_o;
  logic [63:0]        raw_field_o;
  logic [1:0]         status_o;

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  signal_scoreboard book = new();

  can_signal_extractor u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (valid_i),
    .stall_o        (stall_o),
    .frame_data_i   (frame_data_i),
    .frame_length_i (frame_length_i),
    .start_bit_i    (start_bit_i),
    .bit_length_i   (bit_length_i),
    .is_signed_i    (is_signed_i),
    .byte_order_i   (byte_order_i),
    .scale_i        (scale_i),
    .offset_i       (offset_i),
    .command_i      (command_i),
    .valid_o        (valid_o),
    .stall_i        (stall_i),
    .value_o        (value_o),
    .raw_field_o    (raw_field_o),
    .status_o       (status_o)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Receiver stalls at random
  always @(posedge clk_i) begin
    stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // Result monitor
  always @(posedge clk_i) begin
    if (rst_ni && valid_o && !stall_i) book.check_result(value_o, raw_field_o, status_o);
  end

  function automatic item_t make_request(logic [63:0] data, int dlc, int sb, int len,
                                         logic sgn, logic order, logic [31:0] scale,
                                         logic [47:0] offset, cmd_e cmd);
    item_t r;
    r.data   = data;
    r.dlc    = 4'(dlc);
    r.sb     = 6'(sb);
    r.len    = 7'(len);
    r.sgn    = sgn;
    r.order  = order;
    r.scale  = scale;
    r.offset = offset;
    r.cmd    = cmd;
    return r;
  endfunction

  // Random request: mostly well-formed descriptors, some noise
  function automatic item_t gen_signal_request();
    item_t       r;
    int unsigned dlc, fb, len, m;
    logic [63:0] wide;
    r.data  = {$urandom, $urandom};
    r.sgn   = 1'($urandom_range(1));
    r.order = 1'($urandom_range(1));
    r.cmd   = cmd_e'($urandom_range(3));
    if ($urandom_range(99) < 15) begin
      r.dlc = 4'($urandom_range(15));
      r.sb  = 6'($urandom_range(63));
      r.len = 7'($urandom_range(127));
    end else begin
      dlc = $urandom_range(8, 1);
      fb  = dlc * 8;
      case ($urandom_range(9))
        0:             len = fb;
        1, 2, 3, 4, 5: len = $urandom_range((fb < 16) ? fb : 16, 1);
        default:       len = $urandom_range(fb, 1);
      endcase
      r.dlc = 4'(dlc);
      r.len = 7'(len);
      if (r.order == ORDER_INTEL) begin
        r.sb = 6'($urandom_range(fb - len));
      end else begin
        m    = $urandom_range(fb - 1, len - 1);
        r.sb = 6'((dlc - 1 - m / 8) * 8 + m % 8);
      end
    end
    case ($urandom_range(3))
      0:       r.scale = $urandom;
      1:       r.scale = 32'd1 << $urandom_range(24);
      2:       r.scale = 32'd0 - $urandom_range(1 << 26);
      default: r.scale = $urandom_range(1 << 26);
    endcase
    wide = {$urandom, $urandom};
    case ($urandom_range(3))
      0:       r.offset = wide[47:0];
      1:       r.offset = 48'd0;
      2:       r.offset = 48'd0 - 48'($urandom_range(1 << 30));
      default: r.offset = 48'($urandom_range(1 << 30));
    endcase
    return r;
  endfunction

  // Present one request, with an optional gap before it, until accepted
  task automatic send_request(input item_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      valid_i <= 1'b0;
      @(posedge clk_i);
    end
    frame_data_i   <= r.data;
    frame_length_i <= r.dlc;
    start_bit_i    <= r.sb;
    bit_length_i   <= r.len;
    is_signed_i    <= r.sgn;
    byte_order_i   <= r.order;
    scale_i        <= r.scale;
    offset_i       <= r.offset;
    command_i      <= r.cmd;
    valid_i        <= 1'b1;
    @(posedge clk_i);
    while (stall_o) @(posedge clk_i);
    book.note_request(r);
  endtask

  // Overall time limit
  initial begin
    #10_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

  // Main sequence
  initial begin
    logic [63:0] d;
    int          phase;
    d              = 64'hF1E2_D3C4_B5A6_9788;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    rst_ni         <= 1'b0;
    valid_i        <= 1'b0;
    stall_i        <= 1'b0;
    frame_data_i   <= 64'd0;
    frame_length_i <= 4'd0;
    start_bit_i    <= 6'd0;
    bit_length_i   <= 7'd0;
    is_signed_i    <= 1'b0;
    byte_order_i   <= ORDER_INTEL;
    scale_i        <= 32'sd0;
    offset_i       <= 48'sd0;
    command_i      <= CMD_FIXED;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: plain fields, full width, error and out-of-frame cases
    send_request(make_request(d, 8, 0, 8, 0, ORDER_INTEL, SCALE_ONE, 0, CMD_FIXED));
    send_request(make_request(d, 8, 7, 16, 1, ORDER_MOTOROLA, SCALE_ONE, 0, CMD_SINT));
    send_request(make_request(d, 8, 0, 64, 1, ORDER_INTEL, 32'h7FFF_FFFF, 0, CMD_FIXED));
    send_request(make_request(d, 8, 7, 64, 0, ORDER_MOTOROLA, 32'h8000_0000, 0, CMD_UINT));
    send_request(make_request(d, 9, 0, 8, 0, ORDER_INTEL, SCALE_ONE, 1, CMD_FIXED));
    send_request(make_request(d, 15, 63, 8, 1, ORDER_MOTOROLA, SCALE_ONE, 1, CMD_BOOL));
    send_request(make_request(d, 8, 0, 0, 0, ORDER_INTEL, SCALE_ONE, 1, CMD_FIXED));
    send_request(make_request(d, 8, 0, 65, 0, ORDER_MOTOROLA, SCALE_ONE, 1, CMD_UINT));
    send_request(make_request(d, 8, 63, 127, 1, ORDER_INTEL, SCALE_ONE, 1, CMD_SINT));
    // Intel field running past the frame end
    send_request(make_request(d, 2, 10, 8, 0, ORDER_INTEL, SCALE_ONE, 48'h0000_0300_0000,
                              CMD_SINT));
    // Motorola start byte beyond the frame
    send_request(make_request(d, 2, 20, 4, 0, ORDER_MOTOROLA, SCALE_ONE, 48'hFFFF_FE00_0000,
                              CMD_FIXED));
    // Motorola LSB would fall before bit 0
    send_request(make_request(d, 1, 3, 8, 0, ORDER_MOTOROLA, SCALE_ONE, 48'h0000_0100_0000,
                              CMD_BOOL));
    // Zero length code
    send_request(make_request(d, 0, 0, 1, 0, ORDER_INTEL, SCALE_ONE, 48'hFFFF_FF80_0000,
                              CMD_SINT));
    send_request(make_request(d, 0, 7, 8, 0, ORDER_MOTOROLA, SCALE_ONE, 0, CMD_BOOL));
    // Bytes beyond the length code must be ignored
    send_request(make_request({64{1'b1}}, 3, 16, 8, 0, ORDER_INTEL, SCALE_ONE, 0, CMD_UINT));
    // Saturation both ways
    send_request(make_request({64{1'b1}}, 8, 0, 64, 0, ORDER_INTEL, 32'h7FFF_FFFF,
                              48'h7FFF_FFFF_FFFF, CMD_FIXED));
    send_request(make_request(64'h8000_0000_0000_0000, 8, 0, 64, 1, ORDER_INTEL,
                              32'h7FFF_FFFF, 48'h8000_0000_0000, CMD_SINT));
    // Negative value under the unsigned command
    send_request(make_request(64'hFF, 1, 0, 8, 1, ORDER_INTEL, SCALE_ONE, 0, CMD_UINT));
    send_request(make_request(d, 8, 0, 4, 0, ORDER_INTEL, 32'h1, 0, CMD_BOOL));
    send_request(make_request(d, 8, 0, 8, 0, ORDER_INTEL, 32'h0, 0, CMD_BOOL));
    // Offset extremes
    send_request(make_request(d, 8, 0, 8, 0, ORDER_INTEL, 32'h0, 48'h7FFF_FFFF_FFFF, CMD_SINT));
    send_request(make_request(d, 8, 0, 8, 0, ORDER_INTEL, 32'h0, 48'h8000_0000_0000, CMD_UINT));
    // Single-bit fields at the frame corners
    send_request(make_request(d, 1, 0, 1, 1, ORDER_MOTOROLA, SCALE_ONE, 0, CMD_SINT));
    send_request(make_request({64{1'b1}}, 8, 63, 1, 1, ORDER_INTEL, SCALE_ONE, 0, CMD_FIXED));
    // Integer part truncates toward zero: -3 * 0.5
    send_request(make_request(64'hD, 1, 0, 4, 1, ORDER_INTEL, 32'h0080_0000, 0, CMD_SINT));

    // Random requests under each idling pattern
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 50; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 50; end
        default: begin send_idle_pct = 35; recv_stall_pct = 35; end
      endcase
      repeat (490) send_request(gen_signal_request());
    end
    valid_i <= 1'b0;

    // Drain, then allow for the pipeline depth
    while (book.pending_results.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);

    $display("tb_top: %0d decoded signals compared (%0d in frame, %0d bad length, %0d outside)",
             book.checked, book.n_ok, book.n_bad_len, book.n_outside);
    $display("tb_top: four idling patterns run, %0d field mismatches", book.mismatches);
    if (book.mismatches == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/cse_pkg.sv
sv/cse_extract.sv
sv/cse_arith.sv
sv/cse_format.sv
sv/can_signal_extractor.sv
sv/cse_checker.sv
tb/sv/tb_top.sv
